/* src/min_coin_change_assert.svh */
// Assertion macros for the minimum coin change block
`ifndef MIN_COIN_CHANGE_ASSERT_SVH
`define MIN_COIN_CHANGE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define MCC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define MCC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/mcc_pkg.sv */
// Shared types and constants of the minimum coin change block
package mcc_pkg;

	localparam int MAX_AMOUNT_DEF = 4095;
	localparam int NUM_COINS      = 4;
	localparam int COIN_W         = 12;
	localparam int CNT_W          = 12;
	localparam int BEST_W         = 13;
	localparam int CIDX_W         = $clog2(NUM_COINS);

	localparam logic [BEST_W-1:0] BEST_INF = {BEST_W{1'b1}};

	typedef logic [NUM_COINS-1:0][COIN_W-1:0] coin_vec_t;
	typedef logic [NUM_COINS-1:0][CNT_W-1:0]  cnt_vec_t;

	localparam coin_vec_t COIN_RESET = {12'd10, 12'd5, 12'd2, 12'd1};

	// Controller to datapath
	typedef struct packed {
		logic              load;
		logic              init;
		logic              clr_best;
		logic              rd_en;
		logic [CIDX_W-1:0] rd_coin;
		logic              eval;
		logic [CIDX_W-1:0] ev_coin;
		logic              wr_j;
		logic              tr_rd;
		logic              tr_ev;
		logic              fin;
		logic              fin_ok;
	} mcc_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic range_ok;
		logic target_zero;
		logic j_last;
		logic last_inf;
		logic from_zero;
	} mcc_stat_t;

endpackage

/* src/mcc_regs.sv */
// APB-style register file holding the four coin denominations
module mcc_regs import mcc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output coin_vec_t   coins
);

	coin_vec_t         coins_q;
	logic [CIDX_W-1:0] idx;

	assign idx    = paddr[3:2];
	assign pready = 1'b1;
	assign coins  = coins_q;
	assign prdata = {{(32-COIN_W){1'b0}}, coins_q[idx]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coins_q <= COIN_RESET;
		end else if (psel && penable && pwrite) begin
			coins_q[idx] <= pwdata[COIN_W-1:0];
		end
	end

endmodule

/* src/mcc_ctrl.sv */
// Controller sequencing table fill, traceback and result delivery
module mcc_ctrl import mcc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  mcc_stat_t stat,
	output mcc_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	typedef enum logic [2:0] {
		S_IDLE, S_CHECK_IN, S_INIT, S_FILL, S_CHECK, S_TR_RD, S_TR_EV, S_FIN
	} state_t;

	state_t     state_q;
	logic [2:0] step_q;
	logic       ok_q;
	logic       done_q;

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:  cmd.load = start;
			S_INIT:  cmd.init = 1'b1;
			S_FILL: begin
				unique case (step_q)
					3'd0: begin
						cmd.clr_best = 1'b1;
						cmd.rd_en    = 1'b1;
						cmd.rd_coin  = '0;
					end
					3'd1, 3'd2, 3'd3: begin
						cmd.eval    = 1'b1;
						cmd.ev_coin = CIDX_W'(step_q - 3'd1);
						cmd.rd_en   = 1'b1;
						cmd.rd_coin = step_q[CIDX_W-1:0];
					end
					3'd4: begin
						cmd.eval    = 1'b1;
						cmd.ev_coin = CIDX_W'(NUM_COINS - 1);
						cmd.wr_j    = 1'b1;
					end
					default: cmd = '0;
				endcase
			end
			S_TR_RD: cmd.tr_rd = 1'b1;
			S_TR_EV: cmd.tr_ev = 1'b1;
			S_FIN: begin
				cmd.fin    = 1'b1;
				cmd.fin_ok = ok_q;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			ok_q    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) state_q <= S_CHECK_IN;
				end
				S_CHECK_IN: begin
					priority if (!stat.range_ok) begin
						ok_q    <= 1'b0;
						state_q <= S_FIN;
					end else if (stat.target_zero) begin
						ok_q    <= 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					step_q  <= '0;
					state_q <= S_FILL;
				end
				S_FILL: begin
					if (step_q == 3'd4) begin
						step_q <= '0;
						if (stat.j_last) state_q <= S_CHECK;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_CHECK: begin
					if (stat.last_inf) begin
						ok_q    <= 1'b0;
						state_q <= S_FIN;
					end else begin
						state_q <= S_TR_RD;
					end
				end
				S_TR_RD: state_q <= S_TR_EV;
				S_TR_EV: begin
					if (stat.from_zero) begin
						ok_q    <= 1'b1;
						state_q <= S_FIN;
					end else begin
						state_q <= S_TR_RD;
					end
				end
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* src/mcc_dp.sv */
// Datapath: count and predecessor tables, fill evaluation and traceback counters
module mcc_dp import mcc_pkg::*; #(
	parameter int MAX_AMOUNT = MAX_AMOUNT_DEF
) (
	input  logic              clk,
	input  mcc_cmd_t          cmd,
	input  logic [COIN_W-1:0] amount,
	input  coin_vec_t         coins,
	output mcc_stat_t         stat,
	output logic              solvable,
	output logic [CNT_W-1:0]  total_coins,
	output cnt_vec_t          counts
);

	localparam int DEPTH = MAX_AMOUNT + 1;
	localparam int AW    = $clog2(DEPTH);

	logic [BEST_W-1:0] best_mem [DEPTH];
	logic [AW-1:0]     pred_mem [DEPTH];

	logic [AW-1:0]     target_q, j_q, from_q, pos_q, rd_pred_q;
	logic [BEST_W-1:0] best_q, rd_best_q;
	logic              range_ok_q, tz_q, last_inf_q;
	logic [CNT_W-1:0]  total_q, out_total_q;
	cnt_vec_t          cnt_q, out_cnt_q;
	logic              sol_q;

	logic [COIN_W-1:0] rd_d, ev_d;
	logic              rd_ok, ev_ok;
	logic [AW-1:0]     raddr, tr_d, nxt_from;
	logic [BEST_W-1:0] cand, nxt_best;
	logic [NUM_COINS-1:0] hit;

	// Read address for the coin being fetched; unusable coins read entry zero
	assign rd_d  = coins[cmd.rd_coin];
	assign rd_ok = (rd_d != '0) && (32'(rd_d) <= 32'(j_q));
	assign raddr = rd_ok ? (j_q - AW'(rd_d)) : '0;

	assign ev_d  = coins[cmd.ev_coin];
	assign ev_ok = (ev_d != '0) && (32'(ev_d) <= 32'(j_q)) && (rd_best_q != BEST_INF);
	assign cand  = rd_best_q + BEST_W'(1);

	always_comb begin
		nxt_best = best_q;
		nxt_from = from_q;
		// replace only on strict improvement so the earliest coin wins ties
		if (cmd.eval && ev_ok && (cand < best_q)) begin
			nxt_best = cand;
			nxt_from = j_q - AW'(ev_d);
		end
	end

	assign tr_d = pos_q - rd_pred_q;

	always_comb begin
		logic found;
		found = 1'b0;
		hit   = '0;
		// credit the first register holding this denomination
		for (int c = 0; c < NUM_COINS; c++) begin
			if (!found && (32'(coins[c]) == 32'(tr_d))) begin
				hit[c] = 1'b1;
				found  = 1'b1;
			end
		end
	end

	assign stat.range_ok    = range_ok_q;
	assign stat.target_zero = tz_q;
	assign stat.j_last      = (j_q == target_q);
	assign stat.last_inf    = last_inf_q;
	assign stat.from_zero   = (rd_pred_q == '0);

	assign solvable    = sol_q;
	assign total_coins = out_total_q;
	assign counts      = out_cnt_q;

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			best_mem[0] <= '0;
		end else if (cmd.wr_j) begin
			best_mem[j_q] <= nxt_best;
			pred_mem[j_q] <= nxt_from;
		end
		if (cmd.rd_en) rd_best_q <= best_mem[raddr];
		if (cmd.tr_rd) rd_pred_q <= pred_mem[pos_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			target_q   <= AW'(amount);
			pos_q      <= AW'(amount);
			range_ok_q <= (32'(amount) <= 32'(MAX_AMOUNT));
			tz_q       <= (amount == '0);
			j_q        <= AW'(1);
			total_q    <= '0;
			cnt_q      <= '0;
		end
		if (cmd.clr_best) begin
			best_q <= BEST_INF;
			from_q <= '0;
		end else if (cmd.eval) begin
			best_q <= nxt_best;
			from_q <= nxt_from;
		end
		if (cmd.wr_j) begin
			j_q        <= j_q + AW'(1);
			last_inf_q <= (nxt_best == BEST_INF);
		end
		if (cmd.tr_ev) begin
			pos_q   <= rd_pred_q;
			total_q <= total_q + CNT_W'(1);
			for (int c = 0; c < NUM_COINS; c++) begin
				if (hit[c]) cnt_q[c] <= cnt_q[c] + CNT_W'(1);
			end
		end
		if (cmd.fin) begin
			sol_q       <= cmd.fin_ok;
			out_total_q <= total_q;
			out_cnt_q   <= cnt_q;
		end
	end

endmodule

/* src/min_coin_change.sv */
// An amount of zero or one beyond MAX_AMOUNT skips the table fill and traceback and
// goes straight to the result. The fill sequencer reads one coin at a time per amount
// on the single table read port, and traceback reads then evaluates one link per coin;
// the next request can be taken while done is high.
// Reset restores coins 1, 2, 5, 10; the tables need no clearing pass.
// The result is shown under a one-cycle done strobe that cannot be stalled.
module min_coin_change import mcc_pkg::*; #(
	parameter int MAX_AMOUNT = MAX_AMOUNT_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              start,
	output logic              busy,
	input  logic [COIN_W-1:0] amount,
	output logic              done,
	output logic              solvable,
	output logic [CNT_W-1:0]  total_coins,
	output logic [CNT_W-1:0]  count_one,
	output logic [CNT_W-1:0]  count_two,
	output logic [CNT_W-1:0]  count_three,
	output logic [CNT_W-1:0]  count_four
);

`include "min_coin_change_assert.svh"

	coin_vec_t coins;
	mcc_cmd_t  cmd;
	mcc_stat_t stat;
	cnt_vec_t  counts;

	mcc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coins   (coins)
	);

	mcc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	mcc_dp #(
		.MAX_AMOUNT (MAX_AMOUNT)
	) u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.amount      (amount),
		.coins       (coins),
		.stat        (stat),
		.solvable    (solvable),
		.total_coins (total_coins),
		.counts      (counts)
	);

	assign count_one   = counts[0];
	assign count_two   = counts[1];
	assign count_three = counts[2];
	assign count_four  = counts[3];

	`MCC_ASSERT_NXT(a_accept_busy, start && !busy, busy, "request accepted but block not busy")
	`MCC_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")
	`MCC_ASSERT_NXT(a_done_single, done, !done, "result strobe longer than one cycle")
	`MCC_ASSERT_NOW(a_unsolv_zero, done && !solvable,
		total_coins == '0 && count_one == '0 && count_two == '0, "unsolvable result with coins")

endmodule

/* dv/tb.sv */
// Self-checking testbench for the minimum coin change block
module tb;
	import mcc_pkg::*;

	localparam int WATCHDOG_LIMIT = 150000;
	localparam int UNREACHED      = 1 << 30;

	typedef enum int {
		REG_COIN_ONE   = 0,
		REG_COIN_TWO   = 1,
		REG_COIN_THREE = 2,
		REG_COIN_FOUR  = 3
	} coin_reg_e;

	typedef struct packed {
		logic             solvable;
		logic [CNT_W-1:0] total;
		cnt_vec_t         counts;
	} change_t;

	class change_ledger;
		coin_vec_t   coins;
		change_t     pending[$];
		int unsigned faults;
		int          best_tab[0:MAX_AMOUNT_DEF];
		int          link_tab[0:MAX_AMOUNT_DEF];

		function new();
			coins  = COIN_RESET;
			faults = 0;
		endfunction

		// Fewest coins by table fill, then walk the links back from the target
		function change_t solve_change(logic [COIN_W-1:0] target);
			change_t res;
			int      t, j, c, d, pos, prev;
			res = '0;
			t   = target;
			if (t > MAX_AMOUNT_DEF)
				return res;
			best_tab[0] = 0;
			link_tab[0] = 0;
			for (j = 1; j <= t; j++) begin
				best_tab[j] = UNREACHED;
				link_tab[j] = 0;
				for (c = 0; c < NUM_COINS; c++) begin
					d = coins[c];
					if (d == 0 || d > j)
						continue;
					if (best_tab[j-d] == UNREACHED)
						continue;
					// replace only on strict improvement: earliest coin wins ties
					if (best_tab[j-d] + 1 < best_tab[j]) begin
						best_tab[j] = best_tab[j-d] + 1;
						link_tab[j] = j - d;
					end
				end
			end
			if (best_tab[t] == UNREACHED)
				return res;
			pos = t;
			while (pos != 0) begin
				prev = link_tab[pos];
				d    = pos - prev;
				// credit the first register holding this value
				for (c = 0; c < NUM_COINS; c++) begin
					if (coins[c] == d) begin
						res.counts[c] = res.counts[c] + 1'b1;
						break;
					end
				end
				res.total = res.total + 1'b1;
				pos       = prev;
			end
			res.solvable = 1'b1;
			return res;
		endfunction

		function void note_request(logic [COIN_W-1:0] target);
			pending = {pending, solve_change(target)};
		endfunction

		function void check_change(change_t got);
			change_t want;
			int      c;
			if (pending.size() == 0) begin
				$display("%0t: result with no request outstanding", $time);
				faults++;
				return;
			end
			want = pending.pop_front();
			if (got.solvable !== want.solvable) begin
				$display("%0t: solvable expected %0d got %0d", $time, want.solvable,
					got.solvable);
				faults++;
			end
			if (got.total !== want.total) begin
				$display("%0t: total_coins expected %0d got %0d", $time, want.total,
					got.total);
				faults++;
			end
			for (c = 0; c < NUM_COINS; c++) begin
				if (got.counts[c] !== want.counts[c]) begin
					$display("%0t: count of coin %0d expected %0d got %0d", $time, c,
						want.counts[c], got.counts[c]);
					faults++;
				end
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [3:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              start;
	logic              busy;
	logic [COIN_W-1:0] amount;
	logic              done;
	logic              solvable;
	logic [CNT_W-1:0]  total_coins;
	logic [CNT_W-1:0]  count_one;
	logic [CNT_W-1:0]  count_two;
	logic [CNT_W-1:0]  count_three;
	logic [CNT_W-1:0]  count_four;

	change_ledger ledger;
	int unsigned  idle_cycles;

	min_coin_change dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.start       (start),
		.busy        (busy),
		.amount      (amount),
		.done        (done),
		.solvable    (solvable),
		.total_coins (total_coins),
		.count_one   (count_one),
		.count_two   (count_two),
		.count_three (count_three),
		.count_four  (count_four)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial ledger = new();

	always @(posedge clk) begin
		if (arst_n && done)
			ledger.check_change({solvable, total_coins,
				{count_four, count_three, count_two, count_one}});
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic write_coin(coin_reg_e idx, logic [COIN_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 4'(idx * 4);
		pwdata  <= {20'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		ledger.coins[idx] = value;
	endtask

	task automatic load_coins(logic [COIN_W-1:0] c1, logic [COIN_W-1:0] c2,
		logic [COIN_W-1:0] c3, logic [COIN_W-1:0] c4);
		write_coin(REG_COIN_ONE, c1);
		write_coin(REG_COIN_TWO, c2);
		write_coin(REG_COIN_THREE, c3);
		write_coin(REG_COIN_FOUR, c4);
	endtask

	// Hold start until the request is taken; start stays high for the next caller
	task automatic send_amount(logic [COIN_W-1:0] value);
		start  <= 1'b1;
		amount <= value;
		do @(posedge clk); while (busy);
		ledger.note_request(value);
	endtask

	task automatic pause_sender(int cycles);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Drop start and wait for every outstanding result and for the block to go idle
	task automatic drain();
		start <= 1'b0;
		while (ledger.pending.size() != 0) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic logic [COIN_W-1:0] pick_coin();
		case ($urandom_range(0, 9))
			0:       return '0;
			7, 8:    return COIN_W'($urandom_range(1, 60));
			9:       return COIN_W'($urandom_range(1, 4095));
			default: return COIN_W'($urandom_range(1, 12));
		endcase
	endfunction

	function automatic logic [COIN_W-1:0] pick_amount();
		if ($urandom_range(0, 19) == 0)
			return COIN_W'($urandom_range(0, 4095));
		return COIN_W'($urandom_range(0, 300));
	endfunction

	task automatic random_phase(int items);
		logic [COIN_W-1:0] c1, c2, c3, c4;
		int                burst;
		c1 = pick_coin();
		c2 = pick_coin();
		c3 = pick_coin();
		c4 = pick_coin();
		// now and then make denominations repeat
		if ($urandom_range(0, 3) == 0)
			c4 = c2;
		load_coins(c1, c2, c3, c4);
		while (items > 0) begin
			burst = $urandom_range(1, 6);
			while (burst > 0 && items > 0) begin
				send_amount(pick_amount());
				burst--;
				items--;
			end
			if ($urandom_range(0, 2) != 0)
				pause_sender($urandom_range(1, 12));
		end
		drain();
	endtask

	initial begin
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		start       = 1'b0;
		amount      = '0;
		idle_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset denominations
		send_amount(12'd0);
		send_amount(12'd1);
		send_amount(12'd3);
		pause_sender(2);
		send_amount(12'd4095);
		send_amount(12'd2048);
		send_amount(12'd1365);
		drain();

		// largest denominations, all equal
		load_coins(12'd4095, 12'd4095, 12'd4095, 12'd4095);
		send_amount(12'd4095);
		send_amount(12'd4094);
		send_amount(12'd0);
		drain();

		// unit coins only: longest traceback
		load_coins(12'd1, 12'd1, 12'd1, 12'd1);
		send_amount(12'd4095);
		send_amount(12'd100);
		drain();

		// a zero denomination and gaps that leave some amounts unreachable
		load_coins(12'd3, 12'd7, 12'd0, 12'd5);
		send_amount(12'd1);
		send_amount(12'd2);
		send_amount(12'd4);
		send_amount(12'd11);
		send_amount(12'd250);
		drain();

		// greedy would fail here; ties between equal-length choices
		load_coins(12'd1, 12'd3, 12'd4, 12'd9);
		send_amount(12'd6);
		send_amount(12'd12);
		drain();
		load_coins(12'd4, 12'd2, 12'd6, 12'd1);
		send_amount(12'd6);
		send_amount(12'd8);
		drain();

		repeat (4) random_phase(20);

		while (ledger.pending.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (ledger.faults == 0 && ledger.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
